>>> src/cc20bc_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 block cipher package
// Shared types, constants and round functions for the ChaCha block pipeline.
// ----------------------------------------------------------------------------
package cc20bc_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef logic [31:0]            word_type;
   typedef word_type [15:0]        state_type;
   typedef logic [7:0][63:0]       block_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_0_7   = 3'd0,
      CSR_KEY_8_15  = 3'd1,
      CSR_KEY_16_23 = 3'd2,
      CSR_KEY_24_31 = 3'd3,
      CSR_LONG_KEY  = 3'd4,
      CSR_COUNTER   = 3'd5,
      CSR_NONCE     = 3'd6
   } csr_index_type;

   localparam word_type CONST_0  = 32'h6170_7865;
   localparam word_type CONST_3  = 32'h6b20_6574;
   localparam word_type SIGMA_1  = 32'h3320_646e;
   localparam word_type SIGMA_2  = 32'h7962_2d32;
   localparam word_type TAU_1    = 32'h3120_646e;
   localparam word_type TAU_2    = 32'h7962_2d36;

   // State word used by role k (a, b, c, d) of quarter q in a column or diagonal round.
   function automatic logic [3:0] qr_index(input logic diag, input logic [1:0] q,
                                           input logic [1:0] k);
      logic [1:0] lane;
      lane = q + (diag ? k : 2'd0);
      return {k, lane};
   endfunction

   // One half of a quarter round: the 16/12 rotations or the 8/7 rotations.
   function automatic quad_type half_quarter(input word_type a, input word_type b,
                                             input word_type c, input word_type d,
                                             input logic second);
      quad_type r;
      word_type dx;
      word_type bx;
      r.a = a + b;
      dx  = d ^ r.a;
      r.d = second ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
      r.c = c + r.d;
      bx  = b ^ r.c;
      r.b = second ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
      return r;
   endfunction

endpackage

>>> src/cc20bc_csr.sv
// ----------------------------------------------------------------------------
// ChaCha20 configuration registers
// Holds key, key length, counter and nonce and forms the starting state.
// ----------------------------------------------------------------------------
module cc20bc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [cc20bc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cc20bc_pkg::CSR_DATA_W-1:0]   csr_data,
   output cc20bc_pkg::state_type               init_state
);
   import cc20bc_pkg::*;

   logic [63:0] key0_ff;
   logic [63:0] key1_ff;
   logic [63:0] key2_ff;
   logic [63:0] key3_ff;
   logic        long_key_ff;
   logic [63:0] counter_ff;
   logic [63:0] nonce_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff     <= '0;
         key1_ff     <= '0;
         key2_ff     <= '0;
         key3_ff     <= '0;
         long_key_ff <= 1'b0;
         counter_ff  <= '0;
         nonce_ff    <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KEY_0_7:   key0_ff     <= csr_data;
            CSR_KEY_8_15:  key1_ff     <= csr_data;
            CSR_KEY_16_23: key2_ff     <= csr_data;
            CSR_KEY_24_31: key3_ff     <= csr_data;
            CSR_LONG_KEY:  long_key_ff <= csr_data[0];
            CSR_COUNTER:   counter_ff  <= csr_data;
            CSR_NONCE:     nonce_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      init_state[0]  = CONST_0;
      init_state[1]  = long_key_ff ? SIGMA_1 : TAU_1;
      init_state[2]  = long_key_ff ? SIGMA_2 : TAU_2;
      init_state[3]  = CONST_3;
      init_state[4]  = key0_ff[31:0];
      init_state[5]  = key0_ff[63:32];
      init_state[6]  = key1_ff[31:0];
      init_state[7]  = key1_ff[63:32];
      init_state[8]  = long_key_ff ? key2_ff[31:0]  : key0_ff[31:0];
      init_state[9]  = long_key_ff ? key2_ff[63:32] : key0_ff[63:32];
      init_state[10] = long_key_ff ? key3_ff[31:0]  : key1_ff[31:0];
      init_state[11] = long_key_ff ? key3_ff[63:32] : key1_ff[63:32];
      init_state[12] = counter_ff[31:0];
      init_state[13] = counter_ff[63:32];
      init_state[14] = nonce_ff[31:0];
      init_state[15] = nonce_ff[63:32];
   end

endmodule

>>> src/cc20bc_half_round.sv
// ----------------------------------------------------------------------------
// ChaCha20 half-round stage
// One registered pipeline stage: four parallel half quarter rounds.
// ----------------------------------------------------------------------------
module cc20bc_half_round #(
   parameter bit DIAG   = 1'b0,
   parameter bit SECOND = 1'b0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   input  cc20bc_pkg::state_type up_state,
   input  cc20bc_pkg::block_type up_data,
   output logic                  dn_valid,
   output cc20bc_pkg::state_type dn_state,
   output cc20bc_pkg::block_type dn_data
);
   import cc20bc_pkg::*;

   logic      valid_ff;
   state_type state_ff;
   state_type state_in;
   block_type data_ff;
   quad_type  res;

   always_comb begin
      state_in = up_state;
      res      = '0;
      for (int q = 0; q < 4; q++) begin
         res = half_quarter(up_state[qr_index(DIAG, q[1:0], 2'd0)],
                            up_state[qr_index(DIAG, q[1:0], 2'd1)],
                            up_state[qr_index(DIAG, q[1:0], 2'd2)],
                            up_state[qr_index(DIAG, q[1:0], 2'd3)],
                            SECOND);
         state_in[qr_index(DIAG, q[1:0], 2'd0)] = res.a;
         state_in[qr_index(DIAG, q[1:0], 2'd1)] = res.b;
         state_in[qr_index(DIAG, q[1:0], 2'd2)] = res.c;
         state_in[qr_index(DIAG, q[1:0], 2'd3)] = res.d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
      data_ff  <= up_data;
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;
   assign dn_data  = data_ff;

endmodule

>>> src/chacha20_block_cipher_top.sv
// ----------------------------------------------------------------------------
// ChaCha20 block cipher
// Fully unrolled ChaCha block pipeline that XORs one 64-byte word per cycle.
//
//   Channel   Ports                                    Handshake
//   input     start, busy, req_plain_bytes_0..7        start while busy is low
//   result    strobe, rsp_cipher_bytes_0..7            strobe for one cycle
//   config    csr_write_en, csr_index, csr_data        write enable, no wait
//
// A new word is taken every cycle; busy is always low.
// Each result passes one register stage per half round plus the final add/XOR.
// Reset clears all valid bits and the configuration registers.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module chacha20_block_cipher_top #(
   parameter int ROUNDS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [63:0]                         req_plain_bytes_0,
   input  logic [63:0]                         req_plain_bytes_1,
   input  logic [63:0]                         req_plain_bytes_2,
   input  logic [63:0]                         req_plain_bytes_3,
   input  logic [63:0]                         req_plain_bytes_4,
   input  logic [63:0]                         req_plain_bytes_5,
   input  logic [63:0]                         req_plain_bytes_6,
   input  logic [63:0]                         req_plain_bytes_7,
   output logic                                strobe,
   output logic [63:0]                         rsp_cipher_bytes_0,
   output logic [63:0]                         rsp_cipher_bytes_1,
   output logic [63:0]                         rsp_cipher_bytes_2,
   output logic [63:0]                         rsp_cipher_bytes_3,
   output logic [63:0]                         rsp_cipher_bytes_4,
   output logic [63:0]                         rsp_cipher_bytes_5,
   output logic [63:0]                         rsp_cipher_bytes_6,
   output logic [63:0]                         rsp_cipher_bytes_7,
   input  logic                                csr_write_en,
   input  logic [cc20bc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cc20bc_pkg::CSR_DATA_W-1:0]   csr_data
);
   import cc20bc_pkg::*;

   localparam int DOUBLE_ROUNDS = (ROUNDS + 1) / 2;
   localparam int NSTAGES       = 4 * DOUBLE_ROUNDS;
   localparam int LATENCY       = NSTAGES + 1;

   state_type            init_state;
   logic [NSTAGES:0]     pipe_valid;
   state_type            pipe_state [NSTAGES+1];
   block_type            pipe_data  [NSTAGES+1];
   logic                 strobe_ff;
   block_type            cipher_ff;
   block_type            cipher_in;
   state_type            key_stream;

   cc20bc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .init_state   (init_state)
   );

   assign busy          = 1'b0;
   assign pipe_valid[0] = start & ~busy;
   assign pipe_state[0] = init_state;
   assign pipe_data[0]  = {req_plain_bytes_7, req_plain_bytes_6, req_plain_bytes_5,
                           req_plain_bytes_4, req_plain_bytes_3, req_plain_bytes_2,
                           req_plain_bytes_1, req_plain_bytes_0};

   for (genvar s = 0; s < NSTAGES; s++) begin : g_stage
      cc20bc_half_round #(
         .DIAG   ((s % 4) >= 2),
         .SECOND ((s % 2) == 1)
      ) u_half_round (
         .clock    (clock),
         .reset    (reset),
         .up_valid (pipe_valid[s]),
         .up_state (pipe_state[s]),
         .up_data  (pipe_data[s]),
         .dn_valid (pipe_valid[s+1]),
         .dn_state (pipe_state[s+1]),
         .dn_data  (pipe_data[s+1])
      );
   end

   // Init state re-read: only change configuration while idle; not enforced.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         key_stream[i] = pipe_state[NSTAGES][i] + init_state[i];
      end
      for (int i = 0; i < 8; i++) begin
         cipher_in[i] = pipe_data[NSTAGES][i] ^ {key_stream[2*i+1], key_stream[2*i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= pipe_valid[NSTAGES];
      end
   end

   always_ff @(posedge clock) begin
      cipher_ff <= cipher_in;
   end

   assign strobe             = strobe_ff;
   assign rsp_cipher_bytes_0 = cipher_ff[0];
   assign rsp_cipher_bytes_1 = cipher_ff[1];
   assign rsp_cipher_bytes_2 = cipher_ff[2];
   assign rsp_cipher_bytes_3 = cipher_ff[3];
   assign rsp_cipher_bytes_4 = cipher_ff[4];
   assign rsp_cipher_bytes_5 = cipher_ff[5];
   assign rsp_cipher_bytes_6 = cipher_ff[6];
   assign rsp_cipher_bytes_7 = cipher_ff[7];

   a_start_gives_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY strobe)
      else $error("accepted word did not produce a result at the expected cycle");

   a_no_spurious_result: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##LATENCY !strobe)
      else $error("result strobe without a matching accepted word");

   a_key_length_constant: assert property (@(posedge clock) disable iff (reset)
      (csr_write_en && csr_index == CSR_LONG_KEY) |=>
      (init_state[1] == ($past(csr_data[0]) ? SIGMA_1 : TAU_1)))
      else $error("key length write did not select the matching constant");

endmodule

>>> test/chacha20_block_cipher_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 block cipher checker
// Watches the configuration, input and result channels of the cipher. It keeps
// its own copy of the key, counter and nonce registers and computes each
// expected cipher word when a word is taken. Results are matched in order and
// compared lane by lane. The failure and outstanding counts go to the top.
// ----------------------------------------------------------------------------
module chacha20_block_cipher_checker #(
   parameter int ROUNDS = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                busy,
   input  logic                                strobe,
   input  logic                                csr_write_en,
   input  logic [cc20bc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [cc20bc_pkg::CSR_DATA_W-1:0]   csr_data,
   input  cc20bc_pkg::block_type               plain_block,
   input  cc20bc_pkg::block_type               cipher_block,
   output int                                  error_count,
   output int                                  pending_count,
   output int                                  checked_count
);
   import cc20bc_pkg::*;

   logic [63:0] key_0_7;
   logic [63:0] key_8_15;
   logic [63:0] key_16_23;
   logic [63:0] key_24_31;
   logic        long_key_sel;
   logic [63:0] counter_value;
   logic [63:0] nonce_word;
   block_type   cipher_fifo [$];

   function automatic word_type rotate_left(input word_type v, input int n);
      return (v << n) | (v >> (32 - n));
   endfunction

   function automatic block_type predict_cipher_block(input block_type plain);
      word_type  init [16];
      word_type  x [16];
      block_type result;
      word_type  lo;
      word_type  hi;
      int        r;
      int        a;
      int        b;
      int        c;
      int        d;
      init[0]  = CONST_0;
      init[1]  = long_key_sel ? SIGMA_1 : TAU_1;
      init[2]  = long_key_sel ? SIGMA_2 : TAU_2;
      init[3]  = CONST_3;
      init[4]  = key_0_7[31:0];
      init[5]  = key_0_7[63:32];
      init[6]  = key_8_15[31:0];
      init[7]  = key_8_15[63:32];
      init[8]  = long_key_sel ? key_16_23[31:0]  : key_0_7[31:0];
      init[9]  = long_key_sel ? key_16_23[63:32] : key_0_7[63:32];
      init[10] = long_key_sel ? key_24_31[31:0]  : key_8_15[31:0];
      init[11] = long_key_sel ? key_24_31[63:32] : key_8_15[63:32];
      init[12] = counter_value[31:0];
      init[13] = counter_value[63:32];
      init[14] = nonce_word[31:0];
      init[15] = nonce_word[63:32];
      for (int i = 0; i < 16; i++) x[i] = init[i];
      // An odd round count still finishes its last double round.
      for (r = ROUNDS; r > 0; r -= 2) begin
         for (int h = 0; h < 2; h++) begin
            for (int q = 0; q < 4; q++) begin
               a = q;
               b = 4 + ((q + h) % 4);
               c = 8 + ((q + 2 * h) % 4);
               d = 12 + ((q + 3 * h) % 4);
               x[a] = x[a] + x[b];
               x[d] = rotate_left(x[d] ^ x[a], 16);
               x[c] = x[c] + x[d];
               x[b] = rotate_left(x[b] ^ x[c], 12);
               x[a] = x[a] + x[b];
               x[d] = rotate_left(x[d] ^ x[a], 8);
               x[c] = x[c] + x[d];
               x[b] = rotate_left(x[b] ^ x[c], 7);
            end
         end
      end
      for (int i = 0; i < 8; i++) begin
         lo = x[2 * i] + init[2 * i];
         hi = x[2 * i + 1] + init[2 * i + 1];
         result[i] = plain[i] ^ {hi, lo};
      end
      return result;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("ERROR at %0t: %s", $time, what);
   endtask

   always @(posedge clock) begin : monitor
      block_type want;
      if (reset) begin
         key_0_7       = '0;
         key_8_15      = '0;
         key_16_23     = '0;
         key_24_31     = '0;
         long_key_sel  = 1'b0;
         counter_value = '0;
         nonce_word    = '0;
         error_count   = 0;
         checked_count = 0;
         cipher_fifo.delete();
         pending_count <= 0;
      end else begin
         if (start && !busy) cipher_fifo.push_back(predict_cipher_block(plain_block));
         if (strobe) begin
            if (cipher_fifo.size() == 0) begin
               report_mismatch("result word with no word outstanding");
            end else begin
               want = cipher_fifo.pop_front();
               checked_count++;
               for (int i = 0; i < 8; i++) begin
                  if (cipher_block[i] !== want[i])
                     report_mismatch($sformatf("cipher_bytes_%0d is %h, expected %h",
                                               i, cipher_block[i], want[i]));
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_KEY_0_7:   key_0_7 = csr_data;
               CSR_KEY_8_15:  key_8_15 = csr_data;
               CSR_KEY_16_23: key_16_23 = csr_data;
               CSR_KEY_24_31: key_24_31 = csr_data;
               CSR_LONG_KEY:  long_key_sel = csr_data[0];
               CSR_COUNTER:   counter_value = csr_data;
               CSR_NONCE:     nonce_word = csr_data;
               default: ;
            endcase
         end
         pending_count <= cipher_fifo.size();
      end
   end

endmodule

>>> test/tb_chacha20_block_cipher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ChaCha20 block cipher testbench
// Drives 64-byte words into the cipher under a series of key, counter and
// nonce settings, both key lengths and the all-zero and all-one extremes among
// them. A directed opening is followed by random words with random sender
// gaps, ending with gap-free traffic. The checker beside the block predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_chacha20_block_cipher_top;
   import cc20bc_pkg::*;

   localparam int ROUNDS      = 20;
   localparam int LATENCY     = 4 * ((ROUNDS + 1) / 2) + 1;
   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASES      = 10;
   localparam int PHASE_WORDS = 50;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] LONG_KEY_OFF_HIGH_BITS = 64'hFFFF_FFFF_FFFF_FFFE;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic                   strobe;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;
   block_type              plain_block = '0;
   wire  [63:0]            rsp_cipher_bytes_0;
   wire  [63:0]            rsp_cipher_bytes_1;
   wire  [63:0]            rsp_cipher_bytes_2;
   wire  [63:0]            rsp_cipher_bytes_3;
   wire  [63:0]            rsp_cipher_bytes_4;
   wire  [63:0]            rsp_cipher_bytes_5;
   wire  [63:0]            rsp_cipher_bytes_6;
   wire  [63:0]            rsp_cipher_bytes_7;
   int                     error_count;
   int                     pending_count;
   int                     checked_count;
   int                     cycle_count = 0;
   int                     setting_count = 0;

   always #5 clock = ~clock;

   chacha20_block_cipher_top #(.ROUNDS(ROUNDS)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_plain_bytes_0  (plain_block[0]),
      .req_plain_bytes_1  (plain_block[1]),
      .req_plain_bytes_2  (plain_block[2]),
      .req_plain_bytes_3  (plain_block[3]),
      .req_plain_bytes_4  (plain_block[4]),
      .req_plain_bytes_5  (plain_block[5]),
      .req_plain_bytes_6  (plain_block[6]),
      .req_plain_bytes_7  (plain_block[7]),
      .strobe             (strobe),
      .rsp_cipher_bytes_0 (rsp_cipher_bytes_0),
      .rsp_cipher_bytes_1 (rsp_cipher_bytes_1),
      .rsp_cipher_bytes_2 (rsp_cipher_bytes_2),
      .rsp_cipher_bytes_3 (rsp_cipher_bytes_3),
      .rsp_cipher_bytes_4 (rsp_cipher_bytes_4),
      .rsp_cipher_bytes_5 (rsp_cipher_bytes_5),
      .rsp_cipher_bytes_6 (rsp_cipher_bytes_6),
      .rsp_cipher_bytes_7 (rsp_cipher_bytes_7),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   chacha20_block_cipher_checker #(.ROUNDS(ROUNDS)) u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .strobe        (strobe),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .plain_block   (plain_block),
      .cipher_block  ({rsp_cipher_bytes_7, rsp_cipher_bytes_6, rsp_cipher_bytes_5,
                       rsp_cipher_bytes_4, rsp_cipher_bytes_3, rsp_cipher_bytes_2,
                       rsp_cipher_bytes_1, rsp_cipher_bytes_0}),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   function automatic logic [63:0] random_lane();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return ALL_ONES;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic block_type random_block();
      block_type b;
      for (int i = 0; i < 8; i++) b[i] = random_lane();
      return b;
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_data     <= data;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [63:0] k0, input logic [63:0] k1,
                                input logic [63:0] k2, input logic [63:0] k3,
                                input logic [63:0] long_key, input logic [63:0] counter,
                                input logic [63:0] nonce);
      write_csr(CSR_KEY_0_7, k0);
      write_csr(CSR_KEY_8_15, k1);
      write_csr(CSR_KEY_16_23, k2);
      write_csr(CSR_KEY_24_31, k3);
      write_csr(CSR_LONG_KEY, long_key);
      write_csr(CSR_COUNTER, counter);
      write_csr(CSR_NONCE, nonce);
      csr_write_en <= 1'b0;
      setting_count++;
   endtask

   task automatic send_word(input block_type b);
      start       <= 1'b1;
      plain_block <= b;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d words outstanding",
                  cycle_count, pending_count);
         $display("** chacha20_block_cipher_top: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      int idle_odds;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: all-zero key, counter and nonce with the short key.
      send_word('0);
      send_word({8{ALL_ONES}});
      send_word({8{64'hAAAA_AAAA_AAAA_AAAA}});
      send_word({8{64'h5555_5555_5555_5555}});
      wait_idle();

      load_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_word('0);
      send_word({8{ALL_ONES}});
      wait_idle();

      // Only bit zero of the key length register counts.
      load_settings(ALL_ONES, ALL_ONES, '0, '0, LONG_KEY_OFF_HIGH_BITS, ALL_ONES, '0);
      send_word('0);
      pause_sender(3);
      send_word({8{ALL_ONES}});
      send_word(random_block());
      wait_idle();

      // A write beyond the register list must leave the settings alone.
      write_csr(CSR_UNUSED_INDEX, ALL_ONES);
      csr_write_en <= 1'b0;
      send_word('0);
      wait_idle();

      load_settings(random_lane(), random_lane(), random_lane(), random_lane(), 64'd1,
                    '0, ALL_ONES);
      send_word(random_block());
      pause_sender(1);
      send_word(random_block());
      send_word(random_block());

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         load_settings(random_lane(), random_lane(), random_lane(), random_lane(),
                       {$urandom, $urandom}, random_lane(), random_lane());
         idle_odds = $urandom_range(2, 8);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (phase < PHASES - 2 && $urandom_range(1, idle_odds) == 1)
               pause_sender($urandom_range(1, 18));
            send_word(random_block());
         end
      end

      wait_idle();
      repeat (LATENCY + 8) @(posedge clock);
      $display("Checked %0d cipher words over %0d key, counter and nonce settings,",
               checked_count, setting_count);
      $display("with both key lengths, sender gaps and back-to-back traffic.");
      if (error_count == 0)
         $display("** chacha20_block_cipher_top: PASSED **");
      else
         $display("** chacha20_block_cipher_top: FAILED **");
      $finish;
   end

endmodule

>>> chacha20_block_cipher_top.f
src/cc20bc_pkg.sv
src/cc20bc_csr.sv
src/cc20bc_half_round.sv
src/chacha20_block_cipher_top.sv
test/chacha20_block_cipher_checker.sv
test/tb_chacha20_block_cipher_top.sv
